[hw/rtl/mrl_pkg.sv]
// Shared types and constants for the message rate limiter.
// No dependencies; imported by every module of the block.
package mrl_pkg;

  localparam int TS_W              = 31;
  localparam int KEY_W             = 64;
  localparam int WIN_W             = 16;
  localparam int ENTRY_W           = KEY_W + TS_W;
  localparam int IN_TDATA_W        = 96;
  localparam int OUT_TDATA_W       = 8;
  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd10;

  // controller -> datapath
  typedef struct packed {
    logic start;   // capture the input transaction, clear scan state
    logic scan;    // step the table scan
    logic commit;  // write back and load the result register
  } mrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // scan over (all live entries examined or key matched), no read in flight
    logic out_free;   // result register can take a new value this cycle
  } mrl_status_t;

endpackage

[hw/rtl/mrl_ctrl.sv]
// Sequencer for the rate limiter: idle, table scan, commit.
// Depends on mrl_pkg; drives mrl_dp through mrl_cmd_t.
module mrl_ctrl
  import mrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  mrl_status_t status,
  output mrl_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold here while the previous result still waits
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/mrl_dp.sv]
// Datapath for the rate limiter: entry memory, fill count, scan compare,
// slot choice, window register and result register. Depends on mrl_pkg.
module mrl_dp
  import mrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mrl_cmd_t               cmd,
  output mrl_status_t            status,
  input  logic [TS_W-1:0]        in_timestamp,
  input  logic [KEY_W-1:0]       in_key,
  input  logic                   cfg_wr_en,
  input  logic [WIN_W-1:0]       cfg_wr_data,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic                   out_should_print,
  output logic                   out_table_full
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(TABLE_ENTRIES);

  // entry word: key in the upper bits, last-allowed time below
  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [WIN_W-1:0] window_r;
  logic [TS_W-1:0]  now_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;   // live entries always form a prefix
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_vld_r, rd_vld_nxt;
  logic             match_r, match_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             match_exp_r, match_exp_nxt;
  logic             exp_found_r, exp_found_nxt;
  logic [IDX_W-1:0] exp_idx_r, exp_idx_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             print_r, full_r;

  logic             stop, issue;
  logic [TS_W-1:0]  rd_time;
  logic [KEY_W-1:0] rd_key;
  logic [TS_W-1:0]  age;
  logic             expired, hit;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             print_nxt, full_nxt;

  assign rd_time = rd_data_r[TS_W-1:0];
  assign rd_key  = rd_data_r[ENTRY_W-1:TS_W];
  assign age     = now_r - rd_time;
  // time running backwards counts as zero elapsed
  assign expired = (now_r >= rd_time) ? (age >= TS_W'(window_r)) : (window_r == '0);
  assign hit     = rd_vld_r && !match_r && (rd_key == key_r);

  assign stop  = (idx_r >= fill_r) || match_r;
  assign issue = cmd.scan && !stop;

  assign status.scan_done = stop && !rd_vld_r;
  assign status.out_free  = !out_vld_r || out_tready;

  always_comb begin
    idx_nxt       = idx_r;
    rd_vld_nxt    = issue;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    match_exp_nxt = match_exp_r;
    exp_found_nxt = exp_found_r;
    exp_idx_nxt   = exp_idx_r;
    if (cmd.start) begin
      idx_nxt       = '0;
      match_nxt     = 1'b0;
      exp_found_nxt = 1'b0;
    end else begin
      if (issue) begin
        idx_nxt = idx_r + 1'b1;
      end
      if (hit) begin
        match_nxt     = 1'b1;
        match_idx_nxt = rd_idx_r;
        match_exp_nxt = expired;
      end
      if (rd_vld_r && !exp_found_r && expired) begin
        exp_found_nxt = 1'b1;
        exp_idx_nxt   = rd_idx_r;
      end
    end
  end

  // slot choice: matching entry, else next free slot, else lowest expired
  always_comb begin
    we        = 1'b0;
    waddr     = fill_r[IDX_W-1:0];
    fill_nxt  = fill_r;
    print_nxt = 1'b1;
    full_nxt  = 1'b0;
    priority if (match_r) begin
      print_nxt = match_exp_r;
      we        = match_exp_r;
      waddr     = match_idx_r;
    end else if (fill_r < DEPTH) begin
      we       = 1'b1;
      fill_nxt = fill_r + 1'b1;
    end else if (exp_found_r) begin
      we    = 1'b1;
      waddr = exp_idx_r;
    end else begin
      full_nxt = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.commit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && we) begin
      mem[waddr] <= {key_r, now_r};
    end
    rd_data_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      now_r <= in_timestamp;
      key_r <= in_key;
    end
    if (issue) begin
      rd_idx_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.commit) begin
      print_r <= print_nxt;
      full_r  <= full_nxt;
    end
    match_idx_r <= match_idx_nxt;
    match_exp_r <= match_exp_nxt;
    exp_idx_r   <= exp_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      fill_r      <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      match_r     <= 1'b0;
      exp_found_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        fill_r <= fill_nxt;
      end
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      match_r     <= match_nxt;
      exp_found_r <= exp_found_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  assign out_tvalid       = out_vld_r;
  assign out_should_print = print_r;
  assign out_table_full   = full_r;

endmodule

[hw/rtl/message_rate_limiter_core.sv]
// Top level of the message rate limiter: controller plus datapath.
// Depends on mrl_pkg, mrl_ctrl and mrl_dp.
//
// - in_*: one transaction per message, a 31-bit timestamp in seconds
//   (non-decreasing) and a 64-bit message key.
// - out_*: exactly one transaction per input, should_print and table_full.
//   table_full is only set with should_print, for a new key with no slot.
// - cfg_wr_en / cfg_wr_data write window_seconds (reset 10); idle only.
// - One message at a time. The scan reads one entry per cycle over the live
//   entries, stopping early on a key match; the next message is taken the
//   cycle after the result is loaded.
// - in_tready returns once the result is loaded, so the next message is
//   taken while the result still waits. If out_tready stays low, that
//   message scans and then holds before commit until the register frees.
// - Synchronous reset empties the table by clearing the fill count, sets
//   the window back to 10 and drops out_tvalid; no clearing pass.
module message_rate_limiter_core
  import mrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // [30:0] timestamp, [94:31] message_key, [95] zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] should_print, [1] table_full, [7:2] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [WIN_W-1:0]       cfg_wr_data
);

  mrl_cmd_t    cmd;
  mrl_status_t status;
  logic        should_print;
  logic        table_full;

  mrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mrl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_timestamp     (in_tdata[TS_W-1:0]),
    .in_key           (in_tdata[TS_W+KEY_W-1:TS_W]),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_should_print (should_print),
    .out_table_full   (table_full)
  );

  assign out_tdata = {{(OUT_TDATA_W-2){1'b0}}, table_full, should_print};

endmodule

[hw/rtl/mrl_checker.sv]
// Port-level checks for message_rate_limiter_core, bound to the top level.
// Depends on mrl_pkg for widths.
module mrl_checker
  import mrl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // a full table is only reported for a message that was let through
  a_full_implies_print: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("table_full set on a suppressed message");

  // one message in flight: input closes right after a transaction
  a_one_in_flight: assert property (@(posedge clk)
    rst_n && in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a message is in progress");

  a_reset_drops_valid: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk)
    rst_n && out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind message_rate_limiter_core mrl_checker u_mrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[bench/message_rate_limiter_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for message_rate_limiter_core: drives message streams,
// predicts allow/suppress/table-full per transaction and scores the results.
// Depends on mrl_pkg and the RTL of message_rate_limiter_core.
module message_rate_limiter_core_tb;
  import mrl_pkg::*;

  localparam int SLOTS       = TABLE_ENTRIES_DEF;
  localparam int QUIET_LIMIT = 2000;  // idle cycles tolerated before timeout
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    logic should_print;
    logic table_full;
  } verdict_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [WIN_W-1:0]       cfg_wr_data = '0;

  message_rate_limiter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow of the key table and the window register
  logic [KEY_W-1:0] slot_key  [SLOTS];
  logic [TS_W-1:0]  slot_time [SLOTS];
  logic             slot_used [SLOTS];
  logic [WIN_W-1:0] window_s = WINDOW_RESET;

  verdict_t         verdicts_due[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  logic [TS_W-1:0]  now_s = '0;

  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int n_allowed = 0;
  int n_suppressed = 0;
  int n_full = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
  end

  // Decide one message against the shadow table and update it. Matching
  // entry first; else lowest free slot, else lowest expired slot, else
  // the message passes unstored with table_full set.
  function automatic void rate_decide(input logic [TS_W-1:0] ts,
                                      input logic [KEY_W-1:0] key,
                                      output logic allow, output logic full);
    int hit;
    int vacant;
    int stale;
    logic [TS_W-1:0] age;
    hit = -1;
    vacant = -1;
    stale = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        // time running backwards counts as no time elapsed
        age = (ts >= slot_time[i]) ? ts - slot_time[i] : '0;
        if (hit < 0 && slot_key[i] == key) hit = i;
        if (stale < 0 && age >= window_s) stale = i;
      end else if (vacant < 0) begin
        vacant = i;
      end
    end
    allow = 1'b1;
    full  = 1'b0;
    if (hit >= 0) begin
      age = (ts >= slot_time[hit]) ? ts - slot_time[hit] : '0;
      if (age < window_s) allow = 1'b0;
      else slot_time[hit] = ts;
    end else if (vacant >= 0 || stale >= 0) begin
      if (vacant < 0) vacant = stale;
      slot_key[vacant]  = key;
      slot_time[vacant] = ts;
      slot_used[vacant] = 1'b1;
    end else begin
      full = 1'b1;
    end
    if (!allow) n_suppressed++;
    else n_allowed++;
    if (full) n_full++;
  endfunction

  // Result side: random back-pressure bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Scoreboard: each result transaction against the oldest expectation
  always @(posedge clk) begin : score
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result transaction, out_tdata=%0h", out_tdata);
        errors++;
      end else begin
        exp_v = verdicts_due.pop_front();
        if (out_tdata[0] !== exp_v.should_print) begin
          $error("should_print expected %0b got %0b", exp_v.should_print, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== exp_v.table_full) begin
          $error("table_full expected %0b got %0b", exp_v.table_full, out_tdata[1]);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles with no transaction", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transaction; valid stays high afterwards so back-to-back
  // sends need no second assignment in the same step.
  task automatic send_message(input logic [TS_W-1:0] ts, input logic [KEY_W-1:0] key);
    verdict_t v;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tdata  <= {1'b0, key, ts};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rate_decide(ts, key, v.should_print, v.table_full);
    verdicts_due.push_back(v);
    items_sent++;
  endtask

  // Stop sending and let every outstanding result arrive
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_s = w;
  endtask

  // Reset window of 10: repeats inside the window, the exact boundary,
  // extreme keys and time running backwards.
  task automatic test_default_window();
    send_message(31'd0, 64'h0);
    send_message(31'd5, 64'h0);
    send_message(31'd9, 64'h0);
    send_message(31'd10, 64'h0);
    send_message(31'd10, '1);
    send_message(31'd11, '1);
    send_message(31'd3, '1);               // backwards, stored key: suppressed
    send_message(31'd3, 64'h5555_AAAA_0F0F_F0F0);  // backwards, new key: allowed
    send_message(31'd20, '1);
    send_message(31'd20, 64'h0);
    now_s = 31'd20;
  endtask

  // Smallest, largest and zero window
  task automatic test_window_extremes();
    set_window(16'd1);
    send_message(31'd40, 64'h1234);
    send_message(31'd40, 64'h1234);
    send_message(31'd41, 64'h1234);
    set_window('1);
    send_message(31'd100, 64'h1234);
    send_message(31'd65000, 64'h1234);
    send_message(31'd65636, 64'h1234);
    set_window('0);                        // out of range: everything passes
    send_message(31'd65636, 64'h1234);
    send_message(31'd65636, 64'h1234);
    send_message(31'd65636, '1);
    now_s = 31'd65636;
  endtask

  // Fill the table with live keys, overflow it, then reuse an expired slot
  task automatic test_table_full();
    logic [KEY_W-1:0] first_key;
    set_window('1);
    now_s = now_s + 31'd100;
    first_key = {$urandom, $urandom};
    send_message(now_s, first_key);
    for (int k = 0; k < 69; k++) send_message(now_s, {$urandom, $urandom});
    send_message(now_s + 31'd1, first_key);
    now_s = now_s + 31'd65535;
    send_message(now_s, {$urandom, $urandom});
    send_message(now_s, first_key);
  endtask

  // Mostly repeats from a small key pool with timestamps paced to the
  // window, some fresh keys, and the odd step backwards in time.
  task automatic test_random_traffic(input int n, input logic [WIN_W-1:0] w,
                                     input bit pause_midway);
    int span;
    int roll;
    logic [KEY_W-1:0] key;
    set_window(w);
    span = (w / 4 > 0) ? int'(w / 4) : 1;
    for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = {$urandom, $urandom};
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) now_s = (now_s > w) ? now_s - TS_W'($urandom_range(0, w)) : '0;
      else now_s = now_s + TS_W'($urandom_range(0, span));
      if ($urandom_range(0, 3) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_message(now_s, key);
      if (pause_midway && k == n / 2) drain_results();
    end
  endtask

  // Timestamps at the top of the range, then back to zero
  task automatic test_wide_time();
    set_window(16'd500);
    send_message(31'h7FFF_FFF0, 64'hA5A5_0000_FFFF_5A5A);
    send_message('1, 64'hA5A5_0000_FFFF_5A5A);
    send_message('1, 64'h8000_0000_0000_0001);
    send_message('0, 64'hA5A5_0000_FFFF_5A5A);
    send_message('0, 64'h7FFF_FFFF_FFFF_FFFE);
    send_message(31'd600, 64'h7FFF_FFFF_FFFF_FFFE);
    send_message(31'd600, 64'hA5A5_0000_FFFF_5A5A);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window();
    test_window_extremes();
    test_table_full();
    test_random_traffic(100, 16'd1, 1'b0);
    test_random_traffic(100, 16'd3, 1'b1);
    test_random_traffic(100, 16'd20, 1'b0);
    test_random_traffic(100, 16'd500, 1'b0);
    test_random_traffic(100, WIN_W'($urandom_range(1, 65535)), 1'b0);
    idle_on = 1'b0;  // closing stretch at full rate
    test_random_traffic(100, '1, 1'b0);
    test_wide_time();

    drain_results();
    repeat (80) @(posedge clk);  // catch any stray result

    $display("covered %0d messages, %0d results: %0d allowed, %0d suppressed, %0d table full",
             items_sent, results_seen, n_allowed, n_suppressed, n_full);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
